@@ src/tmr_pkg.sv @@
package tmr_pkg;

    // Default prescaler width; taps reach down to divide by 1024
    localparam int unsigned PRESCALER_BITS_DEF = 10;

    // Opcodes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // Register selects
    localparam logic [2:0] REG_CTRL   = 3'd0;
    localparam logic [2:0] REG_COUNT  = 3'd1;
    localparam logic [2:0] REG_MASK   = 3'd2;
    localparam logic [2:0] REG_FLAG   = 3'd3;
    localparam logic [2:0] REG_PSCRST = 3'd4;

    // Clock sources
    localparam logic [2:0] CS_STOP   = 3'd0;
    localparam logic [2:0] CS_DIV1   = 3'd1;
    localparam logic [2:0] CS_DIV8   = 3'd2;
    localparam logic [2:0] CS_DIV64  = 3'd3;
    localparam logic [2:0] CS_DIV256 = 3'd4;
    localparam logic [2:0] CS_DIV1K  = 3'd5;
    localparam logic [2:0] CS_FALL   = 3'd6;
    localparam logic [2:0] CS_RISE   = 3'd7;

    typedef struct packed {
        logic [1:0] opcode;
        logic [2:0] reg_select;
        logic [7:0] write_data;
        logic       ext_pin;
    } tmr_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       overflow_irq;
    } tmr_result_t;

endpackage

@@ src/tmr_core.sv @@
module tmr_core
    import tmr_pkg::*;
#(
    parameter int unsigned PRESCALER_BITS = PRESCALER_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_en,
    input  tmr_item_t   item,
    output tmr_result_t result
);

    logic [7:0]                count_reg,   count_next;
    logic [2:0]                csel_reg,    csel_next;
    logic [PRESCALER_BITS-1:0] psc_reg,     psc_next;
    logic                      pin_reg,     pin_next;
    logic                      ovf_reg,     ovf_next;
    logic                      ovie_reg,    ovie_next;

    logic [PRESCALER_BITS-1:0] psc_inc;
    logic                      fire;

    assign psc_inc = psc_reg + {{(PRESCALER_BITS-1){1'b0}}, 1'b1};

    always_comb
    begin
        case (csel_reg)
            CS_DIV1:   fire = 1'b1;
            CS_DIV8:   fire = (psc_inc[2:0] == 3'd0);
            CS_DIV64:  fire = (psc_inc[5:0] == 6'd0);
            CS_DIV256: fire = (psc_inc[7:0] == 8'd0);
            CS_DIV1K:  fire = (psc_inc[9:0] == 10'd0);
            CS_FALL:   fire = pin_reg && !item.ext_pin;
            CS_RISE:   fire = !pin_reg && item.ext_pin;
            default:   fire = 1'b0;
        endcase
    end

    always_comb
    begin
        count_next       = count_reg;
        csel_next        = csel_reg;
        psc_next         = psc_reg;
        pin_next         = pin_reg;
        ovf_next         = ovf_reg;
        ovie_next        = ovie_reg;
        result.read_data = 8'd0;

        if (item_en)
        begin
            case (item.opcode)
                OP_TICK:
                begin
                    psc_next = psc_inc;
                    pin_next = item.ext_pin;
                    if (fire)
                    begin
                        count_next = count_reg + 8'd1;
                        if (count_reg == 8'hFF)
                            ovf_next = 1'b1;
                    end
                end
                OP_READ:
                begin
                    case (item.reg_select)
                        REG_CTRL:  result.read_data = {5'd0, csel_reg};
                        REG_COUNT: result.read_data = count_reg;
                        REG_MASK:  result.read_data = {7'd0, ovie_reg};
                        REG_FLAG:  result.read_data = {7'd0, ovf_reg};
                        default:   result.read_data = 8'd0;
                    endcase
                end
                OP_WRITE:
                begin
                    case (item.reg_select)
                        REG_CTRL:  csel_next  = item.write_data[2:0];
                        REG_COUNT: count_next = item.write_data;
                        REG_MASK:  ovie_next  = item.write_data[0];
                        REG_FLAG:
                        begin
                            if (item.write_data[0])
                                ovf_next = 1'b0;
                        end
                        REG_PSCRST:
                        begin
                            if (item.write_data[0])
                                psc_next = '0;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end

        result.overflow_irq = ovf_next & ovie_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 8'd0;
            csel_reg  <= CS_STOP;
            psc_reg   <= '0;
            pin_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
            ovie_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            csel_reg  <= csel_next;
            psc_reg   <= psc_next;
            pin_reg   <= pin_next;
            ovf_reg   <= ovf_next;
            ovie_reg  <= ovie_next;
        end
    end

endmodule

@@ src/eight_bit_timer_with_prescaler.sv @@
// Eight-bit timer/counter with a shared free-running prescaler.
//
// Input channel (in_valid/in_ready): one item per handshake, either a clock
// tick (opcode 0), a register read (1) or a register write (2), with
// reg_select, write_data and the sampled ext_pin level.
// Output channel (out_valid/out_ready): exactly one result per item, in
// order: read_data (register byte on a read, zero otherwise) and
// overflow_irq (flag AND enable after the item has been applied).
//
// An accepted item waits in the input register and is applied as it moves into
// the result register, which drives the output. Throughput is one item per
// cycle when results are taken; one input and one result register set it.
// When the receiver stalls, the result register holds, the input register
// fills, and in_ready drops only once both are occupied. in_ready is high
// whenever the result register is empty or being taken.
//
// Reset (rst_n, asynchronous, active low) stops the timer: count, clock
// source, prescaler, pin history, flag and enable all clear, and both
// pipeline registers are emptied.
module eight_bit_timer_with_prescaler
    import tmr_pkg::*;
#(
    parameter int unsigned PRESCALER_BITS = PRESCALER_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] opcode,
    input  logic [2:0] reg_select,
    input  logic [7:0] write_data,
    input  logic       ext_pin,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] read_data,
    output logic       overflow_irq
);

    logic        in_vld_reg;
    tmr_item_t   item_reg;
    logic        out_vld_reg;
    tmr_result_t res_reg;
    tmr_result_t res_next;
    logic        advance;
    logic        apply;

    // Result stage can load when empty or being drained this cycle
    assign advance  = !out_vld_reg || out_ready;
    assign apply    = in_vld_reg && advance;
    assign in_ready = !in_vld_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (in_ready)
            in_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= '{opcode: opcode, reg_select: reg_select,
                          write_data: write_data, ext_pin: ext_pin};
    end

    // Timer state and per-item logic; state only moves when apply is high
    tmr_core #(
        .PRESCALER_BITS (PRESCALER_BITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .item_en (apply),
        .item    (item_reg),
        .result  (res_next)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance)
            out_vld_reg <= in_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (apply)
            res_reg <= res_next;
    end

    assign out_valid    = out_vld_reg;
    assign read_data    = res_reg.read_data;
    assign overflow_irq = res_reg.overflow_irq;

endmodule

@@ src/tmr_chk.sv @@
module tmr_chk
    import tmr_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [1:0] opcode,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] read_data,
    input logic       overflow_irq
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            out_valid && $stable(read_data) && $stable(overflow_irq))
        else $error("result changed while stalled");

    // Free or draining output means the input side can take an item
    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || out_ready) |-> in_ready)
        else $error("input blocked while output is free");

    // Non-read item reaches the output with zero data when the output is not stalled
    a_nonread_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && opcode != OP_READ) ##1 out_ready |=>
            out_valid && read_data == 8'd0)
        else $error("non-read item gave non-zero data");

    // Accepted item always yields a result when the output is not stalled
    a_result_due: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) ##1 out_ready |=> out_valid)
        else $error("accepted item gave no result");

endmodule

bind eight_bit_timer_with_prescaler tmr_chk u_tmr_chk (.*);
